// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 256;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned STAT_W  = 2;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [COUNT_W-1:0]       t_count;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/max_stack_count_cache_top.sv =====
// channel   direction  handshake                        payload
// request   in         i_in_valid / o_in_stall          i_req_type, i_push_value
// result    out        o_out_valid / i_out_stall        o_pop_value, o_current_max,
//                                                       o_max_valid, o_status, o_entry_count
//
// A push, a pop on an empty stack and a push on a full stack load the result from
// idle; a successful pop waits in the pop state for the registered read of the value memory.
// The top (maximum, count) pair sits in registers; lower pairs live in memory.
// Reset (synchronous, active low) empties both stacks at once; no clearing pass.
// A request is taken only while the result register is empty or being drained;
// a stalled result holds off the next request, and so does a pop until its pop state ends.
module max_stack_count_cache_top #(
    parameter int unsigned STACK_DEPTH = msc_pkg::DEF_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  msc_pkg::t_data       i_push_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output msc_pkg::t_data       o_pop_value,
    output msc_pkg::t_data       o_current_max,
    output logic                 o_max_valid,
    output msc_pkg::t_status     o_status,
    output msc_pkg::t_count      o_entry_count
);
    import msc_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    t_data          value_mem   [STACK_DEPTH];
    t_data          max_val_mem [STACK_DEPTH];
    logic [CW-1:0]  max_cnt_mem [STACK_DEPTH];

    logic           r_state,   n_state;
    logic [CW-1:0]  r_vtop,    n_vtop;
    logic [CW-1:0]  r_mtop,    n_mtop;
    t_data          r_max_val, n_max_val;
    logic [CW-1:0]  r_max_cnt, n_max_cnt;

    logic           r_out_valid, n_out_valid;
    t_data          r_popped,    n_popped;
    t_data          r_cur_max,   n_cur_max;
    logic           r_max_ok,    n_max_ok;
    t_status        r_status,    n_status;
    t_count         r_entries,   n_entries;

    t_data          r_val_rd;
    t_data          r_pval_rd;
    logic [CW-1:0]  r_pcnt_rd;

    logic           accept;
    logic           out_free;
    logic           load_out;
    logic           v_we;
    logic           p_we;
    logic [AW-1:0]  v_wr_addr;
    logic [AW-1:0]  p_wr_addr;
    logic [AW-1:0]  v_rd_addr;
    logic [AW-1:0]  p_rd_addr;
    logic [CW-1:0]  vtop_m1;
    logic [CW-1:0]  mtop_m1;
    logic [CW-1:0]  mtop_m2;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign vtop_m1   = r_vtop - CW'(1);
    assign mtop_m1   = r_mtop - CW'(1);
    assign mtop_m2   = r_mtop - CW'(2);
    assign v_wr_addr = r_vtop[AW-1:0];
    assign p_wr_addr = mtop_m1[AW-1:0];
    assign v_rd_addr = vtop_m1[AW-1:0];
    // pair below the cached top, needed if the pop retires that top
    assign p_rd_addr = mtop_m2[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_vtop      = r_vtop;
        n_mtop      = r_mtop;
        n_max_val   = r_max_val;
        n_max_cnt   = r_max_cnt;
        n_popped    = '0;
        n_status    = ST_OK;
        load_out    = 1'b0;
        v_we        = 1'b0;
        p_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_PUSH) begin
                        load_out = 1'b1;
                        if (r_vtop == FULL_COUNT) begin
                            n_status = ST_FULL;
                        end else begin
                            v_we   = 1'b1;
                            n_vtop = r_vtop + CW'(1);
                            if (r_mtop == '0) begin
                                n_max_val = i_push_value;
                                n_max_cnt = CW'(1);
                                n_mtop    = CW'(1);
                            end else if (r_max_val == i_push_value) begin
                                n_max_cnt = r_max_cnt + CW'(1);
                            end else if (i_push_value > r_max_val) begin
                                // spill the cached pair and open a new one
                                p_we      = 1'b1;
                                n_max_val = i_push_value;
                                n_max_cnt = CW'(1);
                                n_mtop    = r_mtop + CW'(1);
                            end
                        end
                    end else if (r_vtop == '0) begin
                        load_out = 1'b1;
                        n_status = ST_EMPTY;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                load_out = 1'b1;
                n_state  = S_IDLE;
                n_popped = r_val_rd;
                n_vtop   = vtop_m1;
                if ((r_mtop != '0) && (r_max_val == r_val_rd) && (r_max_cnt != '0)) begin
                    if (r_max_cnt == CW'(1)) begin
                        n_mtop    = mtop_m1;
                        n_max_val = r_pval_rd;
                        n_max_cnt = r_pcnt_rd;
                    end else begin
                        n_max_cnt = r_max_cnt - CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_cur_max   = r_cur_max;
        n_max_ok    = r_max_ok;
        n_entries   = r_entries;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_max_ok    = (n_vtop != '0) && (n_mtop != '0);
            n_cur_max   = n_max_ok ? n_max_val : '0;
            n_entries   = COUNT_W'(n_vtop);
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vtop      <= '0;
            r_mtop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vtop      <= n_vtop;
            r_mtop      <= n_mtop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_val <= n_max_val;
        r_max_cnt <= n_max_cnt;
        if (load_out) begin
            r_popped <= n_popped;
            r_status <= n_status;
        end
        r_cur_max <= n_cur_max;
        r_max_ok  <= n_max_ok;
        r_entries <= n_entries;
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            value_mem[v_wr_addr] <= i_push_value;
        end
        r_val_rd <= value_mem[v_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            max_val_mem[p_wr_addr] <= r_max_val;
            max_cnt_mem[p_wr_addr] <= r_max_cnt;
        end
        r_pval_rd <= max_val_mem[p_rd_addr];
        r_pcnt_rd <= max_cnt_mem[p_rd_addr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_pop_value    = r_popped;
    assign o_current_max  = r_cur_max;
    assign o_max_valid    = r_max_ok;
    assign o_status       = r_status;
    assign o_entry_count  = r_entries;

`ifndef SYNTH
    a_pairs_within_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mtop <= r_vtop)
        else $error("more maximum pairs than stored values");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vtop <= FULL_COUNT)
        else $error("value stack beyond its depth");

    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_out_valid)
        else $error("pop completing into an occupied result register");

    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_IDLE) && r_out_valid)
        else $error("pop did not deliver its result");
`endif

endmodule
